/* sv/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Each macro has a checking form for simulation and an empty form for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that an expression holds at every rising clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* sv/crs_pkg.sv */
package crs_pkg;

	// Field widths.
	localparam int TIME_W   = 31;
	localparam int LEVEL_W  = 2;
	localparam int TOTAL_W  = 32;
	localparam int GAP_W    = 16;
	localparam int MINLEN_W = 16;
	localparam int CREDIT_W = 8;

	// Stream data widths, padded to whole bytes.
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 96;

	// Register port.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Register reset values.
	localparam logic [GAP_W-1:0]    GAP_LIMIT_RST    = GAP_W'(3 * 60 + 10);
	localparam logic [MINLEN_W-1:0] MIN_LENGTH_RST   = MINLEN_W'(5 * 60);
	localparam logic [CREDIT_W-1:0] POINT_CREDIT_RST = CREDIT_W'(60);

	// Result queue.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	// Register indexes.
	typedef enum logic [1:0] {
		REG_GAP_LIMIT    = 2'd0,
		REG_MIN_LENGTH   = 2'd1,
		REG_POINT_CREDIT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [GAP_W-1:0]    gap_limit;
		logic [MINLEN_W-1:0] min_length;
		logic [CREDIT_W-1:0] point_credit;
	} cfg_t;

	typedef struct packed {
		logic               has_run;
		logic [TIME_W-1:0]  run_begin;
		logic [TIME_W-1:0]  run_finish;
		logic [LEVEL_W-1:0] run_level;
		logic [TOTAL_W-1:0] total_seconds;
		logic               list_done;
	} result_t;

	// Up to two results written into the queue per cycle, in order.
	typedef struct packed {
		logic    first_vld;
		result_t first;
		logic    second_vld;
		result_t second;
	} push_t;

endpackage

/* sv/crs_regs.sv */
module crs_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [crs_pkg::PADDR_W-1:0]  paddr,
	input  logic [crs_pkg::PDATA_W-1:0]  pwdata,
	output logic [crs_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output crs_pkg::cfg_t                cfg
);
	import crs_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_limit    <= GAP_LIMIT_RST;
			cfg_q.min_length   <= MIN_LENGTH_RST;
			cfg_q.point_credit <= POINT_CREDIT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_GAP_LIMIT:    cfg_q.gap_limit    <= pwdata[GAP_W-1:0];
				REG_MIN_LENGTH:   cfg_q.min_length   <= pwdata[MINLEN_W-1:0];
				REG_POINT_CREDIT: cfg_q.point_credit <= pwdata[CREDIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back of the register values.
	always_comb begin
		case (idx)
			REG_GAP_LIMIT:    prdata = PDATA_W'(cfg_q.gap_limit);
			REG_MIN_LENGTH:   prdata = PDATA_W'(cfg_q.min_length);
			REG_POINT_CREDIT: prdata = PDATA_W'(cfg_q.point_credit);
			default:          prdata = '0;
		endcase
	end

endmodule

/* sv/crs_core.sv */
`include "assert_macros.svh"

module crs_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  crs_pkg::cfg_t                 cfg,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [crs_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tlast,
	input  logic                          room,
	output crs_pkg::push_t                push
);
	import crs_pkg::*;

	// Input register.
	logic               vld_s1;
	logic [TIME_W-1:0]  time_s1;
	logic [LEVEL_W-1:0] risk_s1;
	logic               last_s1;

	// Run state.
	logic               run_open_q;
	logic [TIME_W-1:0]  start_q;
	logic [TIME_W-1:0]  end_q;
	logic [LEVEL_W-1:0] level_q;
	logic [TOTAL_W-1:0] acc_q;

	logic               adv;
	logic               near_end;
	logic               extend;
	logic               rep1;
	logic               rep2;
	logic               old_ok;
	logic               fin_ok;
	logic [TIME_W-1:0]  gap_d;
	logic [TIME_W-1:0]  old_len;
	logic [TIME_W-1:0]  ext_len;
	logic [TOTAL_W-1:0] old_add;
	logic [TOTAL_W-1:0] fin_add;
	logic [TOTAL_W+1:0] sum1;
	logic [TOTAL_W+1:0] sum2;
	logic [TOTAL_W-1:0] total1;
	logic [TOTAL_W-1:0] total2;
	logic [TIME_W-1:0]  new_start;
	logic [LEVEL_W-1:0] new_level;
	result_t            gap_res;
	result_t            fin_res;

	assign adv      = vld_s1 && room;
	assign s_tready = !vld_s1 || room;

	// Input register: refills in the cycle it drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			time_s1 <= s_tdata[TIME_W-1:0];
			risk_s1 <= s_tdata[TIME_W+LEVEL_W-1:TIME_W];
			last_s1 <= s_tlast;
		end
	end

	// Run decision for the request in the input register.
	always_comb begin
		gap_d    = time_s1 - end_q;
		near_end = (time_s1 < end_q) || (gap_d <= TIME_W'(cfg.gap_limit));
		extend   = run_open_q && near_end;

		// The open run as it stands, closed by a large gap.
		old_len = end_q - start_q;
		old_ok  = !(end_q < start_q) && (old_len >= TIME_W'(cfg.min_length));
		old_add = (end_q == start_q) ? TOTAL_W'(cfg.point_credit) : TOTAL_W'(old_len);
		rep1    = run_open_q && !near_end && old_ok;

		new_start = extend ? start_q : time_s1;
		new_level = (extend && (level_q > risk_s1)) ? level_q : risk_s1;

		// The run left open after this event; a fresh run has zero length.
		ext_len = time_s1 - start_q;
		if (extend) begin
			fin_ok  = !(time_s1 < start_q) && (ext_len >= TIME_W'(cfg.min_length));
			fin_add = (time_s1 == start_q) ? TOTAL_W'(cfg.point_credit) : TOTAL_W'(ext_len);
		end else begin
			fin_ok  = (cfg.min_length == '0);
			fin_add = TOTAL_W'(cfg.point_credit);
		end
		rep2 = last_s1 && fin_ok;

		// Both totals from the same accumulator value, saturating.
		sum1   = {2'b00, acc_q} + {2'b00, (rep1 ? old_add : '0)};
		sum2   = sum1 + {2'b00, (rep2 ? fin_add : '0)};
		total1 = (sum1[TOTAL_W+1:TOTAL_W] != 2'b00) ? '1 : sum1[TOTAL_W-1:0];
		total2 = (sum2[TOTAL_W+1:TOTAL_W] != 2'b00) ? '1 : sum2[TOTAL_W-1:0];

		gap_res.has_run       = 1'b1;
		gap_res.run_begin     = start_q;
		gap_res.run_finish    = end_q;
		gap_res.run_level     = level_q;
		gap_res.total_seconds = total1;
		gap_res.list_done     = 1'b0;

		fin_res.has_run       = rep2;
		fin_res.run_begin     = rep2 ? new_start : '0;
		fin_res.run_finish    = rep2 ? time_s1 : '0;
		fin_res.run_level     = rep2 ? new_level : '0;
		fin_res.total_seconds = total2;
		fin_res.list_done     = 1'b1;

		push.first_vld  = adv && (rep1 || last_s1);
		push.first      = rep1 ? gap_res : fin_res;
		push.second_vld = adv && rep1 && last_s1;
		push.second     = fin_res;
	end

	// Run state update; the last event closes the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q <= 1'b0;
			acc_q      <= '0;
		end else if (adv) begin
			run_open_q <= !last_s1;
			acc_q      <= last_s1 ? '0 : total1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			start_q <= new_start;
			end_q   <= time_s1;
			level_q <= new_level;
		end
	end

	`ASSERT_SAME(a_two_results_order, clk, arst_n, push.second_vld, push.first_vld && push.first.has_run && !push.first.list_done && push.second.list_done, "second result must follow a reported gap run")
	`ASSERT_SAME(a_empty_fields_zero, clk, arst_n, push.first_vld && !push.first.has_run, push.first.run_begin == '0 && push.first.run_finish == '0 && push.first.run_level == '0, "result without a run must carry zero run fields")
	`ASSERT_NEXT(a_list_clears, clk, arst_n, adv && last_s1, !run_open_q && acc_q == '0, "final event must clear the run and the total")

endmodule

/* sv/crs_fifo.sv */
`include "assert_macros.svh"

module crs_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  crs_pkg::push_t   push,
	output logic             room,
	output logic             m_tvalid,
	input  logic             m_tready,
	output crs_pkg::result_t head
);
	import crs_pkg::*;

	result_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_q;
	logic [FIFO_PTR_W-1:0]  rd_q;
	logic [FIFO_CNT_W-1:0]  count_q;
	logic [FIFO_PTR_W-1:0]  wr_next;
	logic [FIFO_CNT_W-1:0]  n_push;
	logic                   pop;

	assign m_tvalid = (count_q != '0);
	assign head     = mem_q[rd_q];
	assign pop      = m_tvalid && m_tready;
	assign room     = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign wr_next  = wr_q + FIFO_PTR_W'(1);
	assign n_push   = FIFO_CNT_W'(push.first_vld) + FIFO_CNT_W'(push.second_vld);

	// Result storage, up to two writes per cycle.
	always_ff @(posedge clk) begin
		if (push.first_vld) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.second_vld) begin
			mem_q[wr_next] <= push.second;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + FIFO_PTR_W'(n_push);
			rd_q    <= rd_q + FIFO_PTR_W'(pop);
			count_q <= count_q + n_push - FIFO_CNT_W'(pop);
		end
	end

	`ASSERT_ALWAYS(a_no_overflow, clk, arst_n, count_q <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")
	`ASSERT_SAME(a_pair_fits, clk, arst_n, push.first_vld, count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2), "write into a queue without room")

endmodule

/* sv/contact_run_segmenter_unit.sv */
// A request passes through the input register and then the result queue before it shows as a result.
// Throughput: one event per cycle while the queue has room; an event that closes a run by gap and ends the list
// gives two results, and the output side takes one result per cycle while m_tready is high.
// A four-entry result queue decouples the two sides; input stalls when fewer than two slots are free.
// Reset (arst_n low, asynchronous) clears the run, the total and the queue, and sets
// the registers to gap_limit 190, min_length 300 and point_credit 60.
module contact_run_segmenter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Registers.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crs_pkg::PADDR_W-1:0]   paddr,
	input  logic [crs_pkg::PDATA_W-1:0]   pwdata,
	output logic [crs_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	// Events.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [crs_pkg::S_TDATA_W-1:0] s_tdata,  // event_time[30:0], event_risk[32:31], zero pad
	input  logic                          s_tlast,  // last_event
	// Results.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [crs_pkg::M_TDATA_W-1:0] m_tdata,  // run_begin[30:0], run_finish[61:31],
	                                                // run_level[63:62], total_seconds[95:64]
	output logic                          m_tuser,  // has_run
	output logic                          m_tlast   // list_done
);
	import crs_pkg::*;

	cfg_t    cfg;
	push_t   push;
	logic    room;
	result_t head;

	crs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crs_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.room     (room),
		.push     (push)
	);

	crs_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	// Result packing.
	assign m_tdata = {head.total_seconds, head.run_level, head.run_finish, head.run_begin};
	assign m_tuser = head.has_run;
	assign m_tlast = head.list_done;

endmodule
